@@ hdl/assert_macros.svh @@
// Assertion macros shared by the hysteresis edge threshold RTL.
// Included by files that check their own logic; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define HET_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hysteresis edge threshold: implication check failed");

// Condition must never hold.
`define HET_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("hysteresis edge threshold: forbidden condition seen");

`else

`define HET_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define HET_ASSERT_NEVER(lbl, clk_s, rst_s, cond)

`endif

`endif

@@ hdl/het_pkg.sv @@
// Shared types and constants for the hysteresis edge threshold block.
// No dependencies; imported by every module of the block.
package het_pkg;

    // Largest supported row length and the derived widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int MAG_W      = 8;
    localparam int THR_W      = 8;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int CMP_W      = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int MIN_DIM    = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_LOW_THR      = 2'd0,
        IDX_HIGH_THR     = 2'd1,
        IDX_FRAME_WIDTH  = 2'd2,
        IDX_FRAME_HEIGHT = 2'd3
    } cfg_index_t;

    localparam logic [THR_W-1:0] LOW_THR_RST      = 8'd50;
    localparam logic [THR_W-1:0] HIGH_THR_RST     = 8'd150;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 16'd480;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output stream packing: edge flag, column, row, zero filled to bytes.
    localparam int OUT_BITS   = 1 + COL_W + ROW_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Current and previous rows of a 3x3 window; the oldest row is excluded.
    localparam logic [8:0] RING_MASK = 9'h0DB;

    // Active configuration, dimensions already clamped to legal range.
    typedef struct packed {
        logic [THR_W-1:0] low_thr;
        logic [THR_W-1:0] high_thr;
        logic [CMP_W-1:0] w_dim;
        logic [FH_W-1:0]  h_dim;
    } cfg_t;

    // One classified pixel handed from the front to the back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             strong_bit;
        logic             weak_bit;
        logic             sp1;
        logic             sp2;
        logic             wp1;
        logic             row_end;
        logic             last_row;
    } item_t;

endpackage

@@ hdl/het_cfg.sv @@
// Configuration register file of the hysteresis edge threshold block.
// Depends on het_pkg for index codes, reset values and the cfg_t struct.
module het_cfg import het_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [THR_W-1:0] low_reg,    low_next;
    logic [THR_W-1:0] high_reg,   high_next;
    logic [FW_W-1:0]  fwidth_reg, fwidth_next;
    logic [FH_W-1:0]  fheight_reg, fheight_next;
    logic [CMP_W-1:0] w_raw;

    assign cfg_ready = 1'b1;

    // Register write decode.
    always_comb
    begin
        low_next     = low_reg;
        high_next    = high_reg;
        fwidth_next  = fwidth_reg;
        fheight_next = fheight_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                IDX_LOW_THR:      low_next     = cfg_data[THR_W-1:0];
                IDX_HIGH_THR:     high_next    = cfg_data[THR_W-1:0];
                IDX_FRAME_WIDTH:  fwidth_next  = cfg_data[FW_W-1:0];
                IDX_FRAME_HEIGHT: fheight_next = cfg_data[FH_W-1:0];
                default:          low_next     = low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg     <= LOW_THR_RST;
            high_reg    <= HIGH_THR_RST;
            fwidth_reg  <= FRAME_WIDTH_RST;
            fheight_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            low_reg     <= low_next;
            high_reg    <= high_next;
            fwidth_reg  <= fwidth_next;
            fheight_reg <= fheight_next;
        end
    end

    // Clamp the frame dimensions to the supported range.
    assign w_raw = CMP_W'(fwidth_reg);

    always_comb
    begin
        cfg.low_thr  = low_reg;
        cfg.high_thr = high_reg;
        if (w_raw < CMP_W'(MIN_DIM))
            cfg.w_dim = CMP_W'(MIN_DIM);
        else if (w_raw > CMP_W'(MAX_WIDTH))
            cfg.w_dim = CMP_W'(MAX_WIDTH);
        else
            cfg.w_dim = w_raw;
        if (fheight_reg < FH_W'(MIN_DIM))
            cfg.h_dim = FH_W'(MIN_DIM);
        else
            cfg.h_dim = fheight_reg;
    end

endmodule

@@ hdl/het_front.sv @@
// Front end: position counters, strong/weak classification and the line store.
// Depends on het_pkg; pushes one item_t per accepted pixel into the queue.
module het_front import het_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MAG_W-1:0]  s_tdata,   // [7:0] pixel_magnitude
    input  logic              s_tuser,   // [0] frame_start
    input  logic [QCNT_W-1:0] q_count,
    output logic              push_valid,
    output item_t             push_item,
    output logic              clearing
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             v1_reg;
    item_t            p1_reg;
    logic             clr_busy_reg;
    logic [COL_W-1:0] clr_addr_reg;

    logic [2:0]       mem [MAX_WIDTH];
    logic [2:0]       rd_data_reg;
    logic             byp_hit_reg;
    logic [2:0]       byp_data_reg;

    logic             accept;
    logic [COL_W-1:0] c_cur;
    logic [ROW_W-1:0] r_cur;
    logic [CMP_W-1:0] c_ext;
    logic             row_end, last_row, inner, is_strong, is_weak;
    logic [2:0]       old_bits, wr_data1;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [2:0]       mem_wdata;

    // Room for the new transaction and the one already in the read stage.
    assign s_tready = !clr_busy_reg &&
        ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(v1_reg) < (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign clearing = clr_busy_reg;

    // Position of the incoming pixel and its classification.
    always_comb
    begin
        c_cur     = s_tuser ? '0 : col_reg;
        r_cur     = s_tuser ? '0 : row_reg;
        c_ext     = CMP_W'(c_cur);
        row_end   = c_ext >= cfg.w_dim - CMP_W'(1);
        last_row  = r_cur >= cfg.h_dim - FH_W'(1);
        inner     = (r_cur != '0) && (r_cur <= cfg.h_dim - FH_W'(2)) &&
                    (c_cur != '0) && (c_ext <= cfg.w_dim - CMP_W'(2));
        is_strong = inner && (s_tdata > cfg.high_thr);
        is_weak   = s_tdata > cfg.low_thr;
    end

    // Counter advance in raster order.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : r_cur + ROW_W'(1);
            end
            else
            begin
                col_next = c_cur + COL_W'(1);
                row_next = r_cur;
            end
        end
    end

    // Control state: counters, read stage valid, clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            v1_reg       <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= accept;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
                if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg.col        <= c_cur;
            p1_reg.row        <= r_cur;
            p1_reg.strong_bit <= is_strong;
            p1_reg.weak_bit   <= is_weak;
            p1_reg.sp1        <= 1'b0;
            p1_reg.sp2        <= 1'b0;
            p1_reg.wp1        <= 1'b0;
            p1_reg.row_end    <= row_end;
            p1_reg.last_row   <= last_row;
            byp_hit_reg       <= v1_reg && (p1_reg.col == c_cur);
            byp_data_reg      <= wr_data1;
        end
    end

    // Stored bits of this column from the row above; row 0 sees zeros.
    always_comb
    begin
        if (p1_reg.row == '0)
            old_bits = 3'b000;
        else if (byp_hit_reg)
            old_bits = byp_data_reg;
        else
            old_bits = rd_data_reg;
        wr_data1 = {p1_reg.weak_bit, old_bits[0], p1_reg.strong_bit};
    end

    // Line store write: clearing pass after reset, then one entry per pixel.
    assign mem_we    = clr_busy_reg || v1_reg;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : p1_reg.col;
    assign mem_wdata = clr_busy_reg ? 3'b000 : wr_data1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_data_reg <= mem[c_cur];
    end

    // Completed item toward the queue.
    always_comb
    begin
        push_item     = p1_reg;
        push_item.sp1 = old_bits[0];
        push_item.sp2 = old_bits[1];
        push_item.wp1 = old_bits[2];
    end
    assign push_valid = v1_reg;

endmodule

@@ hdl/het_queue.sv @@
// Short FIFO of classified pixels between the front and back ends.
// Depends on het_pkg for item_t and the queue depth.
module het_queue import het_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  item_t             push_item,
    input  logic              pop,
    output item_t             head,
    output logic [QCNT_W-1:0] count
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ hdl/het_back.sv @@
// Back end: 3x3 strong window, hysteresis decision and result sequencing.
// Depends on het_pkg; pops items from the queue and drives the output stream.
module het_back import het_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  item_t                 head,
    input  logic [QCNT_W-1:0]     q_count,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // [0] edge_flag, [11:1] pixel_col,
                                            // [27:12] pixel_row, rest zero
    output logic                  m_tlast,  // last_of_run
    output logic                  m_tuser   // [0] frame_done
);

    logic [8:0]       sw_reg;
    logic [1:0]       wd_reg;
    logic [3:0]       pend_mask_reg;
    logic [3:0]       pend_edge_reg;
    logic [COL_W-1:0] pend_col_reg;
    logic [ROW_W-1:0] pend_row_reg;

    logic             out_valid_reg;
    logic             out_edge_reg, out_last_reg, out_done_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic             out_free, emit;
    logic [3:0]       sel_oh, rest;
    logic             q_valid;
    logic [2:0]       tcol;
    logic [8:0]       win, w2;
    logic [3:0]       new_edge, new_mask;
    logic             rfirst, cfirst;

    assign q_valid  = q_count != '0;
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (pend_mask_reg != 4'b0000) && out_free;
    assign sel_oh   = pend_mask_reg & (~pend_mask_reg + 4'd1);
    assign rest     = pend_mask_reg & ~sel_oh;
    assign pop      = q_valid && ((pend_mask_reg == 4'b0000) || (emit && rest == 4'b0000));

    // Window update and the four candidate results of the head item.
    always_comb
    begin
        tcol   = {head.sp2, head.sp1, head.strong_bit};
        win    = (head.col == '0) ? {6'b0, tcol} : {sw_reg[5:0], tcol};
        w2     = {win[5:0], 3'b000};
        rfirst = head.row != '0;
        cfirst = head.col != '0;
        // Center one row up and one column left, then right column, then bottom row.
        new_edge[0] = win[4] | (wd_reg[0] & (win != 9'd0));
        new_edge[1] = w2[4]  | (head.wp1 & (w2 != 9'd0));
        new_edge[2] = win[3] | (wd_reg[1] & ((win & RING_MASK) != 9'd0));
        new_edge[3] = w2[3]  | (head.weak_bit & ((w2 & RING_MASK) != 9'd0));
        new_mask[0] = rfirst && cfirst;
        new_mask[1] = rfirst && head.row_end;
        new_mask[2] = rfirst && head.last_row && cfirst;
        new_mask[3] = rfirst && head.last_row && head.row_end;
    end

    // Window state and pending result mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= '0;
            wd_reg        <= '0;
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sw_reg        <= win;
                wd_reg        <= {head.weak_bit, head.wp1};
                pend_mask_reg <= new_mask;
            end
            else if (emit)
                pend_mask_reg <= rest;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload of the item being sequenced and of the output register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pend_edge_reg <= new_edge;
            pend_col_reg  <= head.col;
            pend_row_reg  <= head.row;
        end
        if (emit)
        begin
            out_edge_reg <= |(pend_edge_reg & sel_oh);
            out_col_reg  <= (sel_oh[0] || sel_oh[2]) ? pend_col_reg - COL_W'(1)
                                                     : pend_col_reg;
            out_row_reg  <= (sel_oh[0] || sel_oh[1]) ? pend_row_reg - ROW_W'(1)
                                                     : pend_row_reg;
            out_last_reg <= rest == 4'b0000;
            out_done_reg <= sel_oh[3];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_row_reg, out_col_reg, out_edge_reg});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule

@@ hdl/hysteresis_edge_threshold_top.sv @@
// Top level of the 3x3 single-pass hysteresis edge threshold block.
// Depends on het_pkg, assert_macros.svh, het_cfg, het_front, het_queue, het_back.
//
// Usage:
//   s_* carries gradient magnitudes in raster order, one pixel per transaction;
//   s_tuser marks the first pixel of a frame. m_* carries one result per
//   transaction: edge flag and the pixel's column and row, m_tlast on the final
//   result caused by an input pixel, m_tuser on the frame's last pixel.
//   cfg_* writes the low/high thresholds and frame width/height by index; it
//   is always ready and is meant to be written while the block is idle.
// Throughput: s_* takes one pixel per cycle while the queue has room and no
//   clearing pass runs. While m_tready is high the sequencer spends one cycle
//   per pixel, or one per result where a pixel causes several (two at a row end
//   and in most of the last row, four at the frame's last pixel); the
//   four-entry queue absorbs the row-end burst.
// Path: a pixel passes the read stage register, the queue, the pending
//   registers and the output register; results trail the input by about one row.
// Reset: a clearing pass writes zeros to all 2048 line store entries, one
//   per cycle; s_tready stays low until the pass ends.
// Stalls: when m_tready is low the result holds in the output register, the
//   queue fills and s_tready drops once it has no room.
`include "assert_macros.svh"

module hysteresis_edge_threshold_top import het_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [MAG_W-1:0]      s_tdata,   // [7:0] pixel_magnitude
    input  logic                  s_tuser,   // [0] frame_start
    // Result output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [0] edge_flag, [11:1] pixel_col,
                                             // [27:12] pixel_row, rest zero
    output logic                  m_tlast,   // last_of_run
    output logic                  m_tuser,   // [0] frame_done
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    logic              q_push, q_pop, clearing;
    item_t             push_item, head;
    logic [QCNT_W-1:0] q_count;

    // Register file.
    het_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Classifier and line store.
    het_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_count    (q_count),
        .push_valid (q_push),
        .push_item  (push_item),
        .clearing   (clearing)
    );

    // Decoupling queue.
    het_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .count     (q_count)
    );

    // Window, decision and result sequencing.
    het_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_count  (q_count),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Checks on the internal flow.
    `HET_ASSERT_IMPL(a_push_has_room, clk, rst_n, q_push, q_count < QCNT_W'(QUEUE_DEPTH))
    `HET_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && (q_count == '0))
    `HET_ASSERT_IMPL(a_clear_is_quiet, clk, rst_n, clearing, (q_count == '0) && !m_tvalid)
    `HET_ASSERT_IMPL(a_done_ends_run, clk, rst_n, m_tvalid && m_tuser, m_tlast)

endmodule
